// ===== rtl/core/bafa_pkg.sv =====
// ----------------------------------------------------------------------------
// bafa_pkg
// Shared constants, types and seed arithmetic for the banded affine aligner.
// ----------------------------------------------------------------------------
`default_nettype none

package bafa_pkg;

    localparam int BAND_WIDTH = 32;
    localparam int MAX_LEN    = 4096;
    localparam int HALF       = BAND_WIDTH / 2;
    localparam int LANE_W     = $clog2(BAND_WIDTH);
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int STEP_W     = LEN_W + 1;
    localparam int CNT_W      = $clog2(HALF + 1);
    localparam int NGRP       = BAND_WIDTH / 4;
    localparam int SCORE_W    = 16;
    localparam int OFS        = 32768;
    localparam int BASE_W     = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [BASE_W-1:0] BASE_N = 3'd4;

    // Register index (byte address bits 3:2)
    typedef enum logic [1:0] {
        REG_MATCH      = 2'd0,
        REG_MISMATCH   = 2'd1,
        REG_GAP_OPEN   = 2'd2,
        REG_GAP_EXTEND = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_APPEND_A = 1'b0,
        OP_APPEND_B = 1'b1
    } t_op;

    // Scoring terms as the cells use them
    typedef struct packed {
        logic [3:0] ma;   // match score
        logic [4:0] mi;   // mismatch score, two's complement
        logic [5:0] gom;  // gap open cost, magnitude
        logic [5:0] gxm;  // gap extend cost, magnitude
    } t_score_cfg;

    typedef struct packed {
        logic clear;
        logic seed;
        logic shift_a;
        logic shift_b;
        logic compute;
    } t_cell_ctrl;

    typedef struct packed {
        logic [SCORE_W-1:0] prev;
        logic [SCORE_W-1:0] cur;
        logic [SCORE_W-1:0] gh;
        logic [SCORE_W-1:0] gv;
    } t_cell_seed;

    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] value;
        logic [LANE_W-1:0]  lane;
        logic [STEP_W-1:0]  step;
    } t_cand;

    typedef logic [BAND_WIDTH-1:0][SCORE_W-1:0] t_band_scores;

    // Starting band values of one lane; all results wrap to 16 bits
    function automatic t_cell_seed seed_lane(input int lane, input t_score_cfg cfg);
        int         ma;
        int         mi;
        int         mm;
        int         go;
        int         gx;
        int         i;
        int         prev;
        int         cur;
        t_cell_seed s;
        ma = int'(cfg.ma);
        mi = cfg.mi[4] ? int'(cfg.mi) - 32 : int'(cfg.mi);
        mm = (ma > mi) ? ma : mi;
        go = -int'(cfg.gom);
        gx = -int'(cfg.gxm);
        if (lane < HALF) begin
            i    = HALF - 1 - lane;
            prev = OFS - (i + 1) * mm + go + 2 * (i + 1) * gx;
            s.gh = (i == 0) ? SCORE_W'(OFS + go + gx) : '0;
            s.gv = '0;
        end else begin
            i    = lane - HALF;
            prev = OFS - i * mm + ((i > 0) ? go : 0) + 2 * i * gx;
            s.gh = '0;
            s.gv = (i == 0) ? SCORE_W'(OFS + go + gx) : '0;
        end
        cur    = OFS - i * mm + go + (2 * i + 1) * gx;
        s.prev = SCORE_W'(prev);
        s.cur  = SCORE_W'(cur);
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/banded_affine_alignment_top.sv =====
// ----------------------------------------------------------------------------
// banded_affine_alignment_top
// Static-band affine-gap aligner run on a row of lane cells.
// ----------------------------------------------------------------------------
// Input channel: each transaction may append one base to sequence a or b
// (up to 4096 each). A transaction with last set starts the alignment and
// both sequences are emptied once the result is taken.
// Output channel: one transaction per alignment with the best score and
// its end positions in a and b.
// Loading accepts a new base with every transaction until last. An alignment
// loads the band (reads of both base stores), then runs len_a + len_b - 1
// anti-diagonal steps, each a registered read of the base store feeding the
// band edge and an execute, then drains the maximum tree. An empty sequence
// gives the result the cycle after.
// Input stall is high from the last transaction until the result is taken;
// while the receiver stalls the result holds.
// Reset restores the scoring registers and empties both sequences; the
// base stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module banded_affine_alignment_top
    import bafa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic [2:0]         i_base_code,
    input  wire logic               i_char_valid,
    input  wire logic               i_last,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [14:0]        o_score,
    output logic      [12:0]        o_a_end,
    output logic      [12:0]        o_b_end
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FILL  = 8'b0000_0010,
        S_SEED  = 8'b0000_0100,
        S_ENC   = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_EX    = 8'b0010_0000,
        S_DRAIN = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [3:0]         r_match;
    logic [4:0]         r_mismatch;
    logic [5:0]         r_gap_open;
    logic [5:0]         r_gap_extend;
    logic [LEN_W-1:0]   r_len_a;
    logic [LEN_W-1:0]   r_len_b;
    logic [LEN_W-1:0]   n_len_a;
    logic [LEN_W-1:0]   n_len_b;
    logic [STEP_W-1:0]  r_total;
    logic [STEP_W-1:0]  r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_fill_v;
    logic               r_in_a;
    logic               r_in_b;
    logic               r_ex_done;
    logic [STEP_W-1:0]  r_ex_p;
    logic [SCORE_W-1:0] r_best;
    logic [STEP_W-1:0]  r_best_step;
    logic [LANE_W-1:0]  r_best_lane;
    logic               r_out_valid;
    logic [14:0]        r_score;
    logic [12:0]        r_a_end;
    logic [12:0]        r_b_end;

    logic               cfg_wr;
    logic               acc_in;
    logic               acc_out;
    logic [BASE_W-1:0]  code_n;
    logic               we_a;
    logic               we_b;
    logic [STEP_W-1:0]  rd_idx;
    logic [BASE_W-1:0]  rdata_a;
    logic [BASE_W-1:0]  rdata_b;
    logic [BASE_W-1:0]  new_a;
    logic [BASE_W-1:0]  new_b;
    t_score_cfg         scfg;
    t_cell_ctrl         ctrl;
    t_cand              cand;
    logic [LANE_W-1:0]  enc_lane;
    logic signed [STEP_W-1:0] q;
    logic [STEP_W:0]    step_inc;
    logic [STEP_W-1:0]  a_pos;
    logic [STEP_W-1:0]  b_pos;
    logic               seq_empty;

    logic [BASE_W-1:0]  w_ca   [BAND_WIDTH];
    logic [BASE_W-1:0]  w_cb   [BAND_WIDTH];
    logic [SCORE_W-1:0] w_gh   [BAND_WIDTH];
    logic [SCORE_W-1:0] w_gv   [BAND_WIDTH];
    logic [BAND_WIDTH-1:0] w_pofs;
    t_band_scores       w_cur;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match      <= 4'd1;
            r_mismatch   <= 5'h1F;
            r_gap_open   <= 6'h3F;
            r_gap_extend <= 6'h3F;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_MATCH:      r_match      <= pwdata[3:0];
                REG_MISMATCH:   r_mismatch   <= pwdata[4:0];
                REG_GAP_OPEN:   r_gap_open   <= pwdata[5:0];
                REG_GAP_EXTEND: r_gap_extend <= pwdata[5:0];
                default:        r_match      <= r_match;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_MATCH:      prdata = PDATA_W'(r_match);
            REG_MISMATCH:   prdata = PDATA_W'(r_mismatch);
            REG_GAP_OPEN:   prdata = PDATA_W'(r_gap_open);
            REG_GAP_EXTEND: prdata = PDATA_W'(r_gap_extend);
            default:        prdata = '0;
        endcase
    end

    // Scoring terms; a positive gap register counts as zero
    assign scfg.ma  = r_match;
    assign scfg.mi  = r_mismatch;
    assign scfg.gom = r_gap_open[5] ? 6'(-r_gap_open) : 6'd0;
    assign scfg.gxm = r_gap_extend[5] ? 6'(-r_gap_extend) : 6'd0;

    // Load handshake and sequence append
    assign o_in_stall = (r_state != S_IDLE);
    assign acc_in     = i_in_valid && !o_in_stall;
    assign acc_out    = r_out_valid && !i_out_stall;
    assign code_n     = (i_base_code > BASE_N) ? BASE_N : i_base_code;
    assign we_a = acc_in && i_char_valid && (t_op'(i_operation) == OP_APPEND_A)
                  && (r_len_a < LEN_W'(MAX_LEN));
    assign we_b = acc_in && i_char_valid && (t_op'(i_operation) == OP_APPEND_B)
                  && (r_len_b < LEN_W'(MAX_LEN));
    assign n_len_a   = r_len_a + LEN_W'(we_a);
    assign n_len_b   = r_len_b + LEN_W'(we_b);
    assign seq_empty = (n_len_a == '0) || (n_len_b == '0);

    // Base read index: seed sweep, then the band edge of each step
    assign rd_idx = r_state[1] ? STEP_W'(r_cnt)
                               : ({1'b0, r_p[STEP_W-1:1]} + STEP_W'(HALF - 1));

    bafa_seqmem u_mem_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_len_a[ADDR_W-1:0]),
        .i_wdata (code_n),
        .i_raddr (rd_idx[ADDR_W-1:0]),
        .o_rdata (rdata_a)
    );

    bafa_seqmem u_mem_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_len_b[ADDR_W-1:0]),
        .i_wdata (code_n),
        .i_raddr (rd_idx[ADDR_W-1:0]),
        .o_rdata (rdata_b)
    );

    // Past the sequence end the band takes N
    assign new_a = r_in_a ? rdata_a : BASE_N;
    assign new_b = r_in_b ? rdata_b : BASE_N;

    // Cell control
    assign ctrl.clear   = acc_in && i_last;
    assign ctrl.seed    = (r_state == S_SEED);
    assign ctrl.shift_a = ((r_state == S_FILL) && r_fill_v) || ((r_state == S_EX) && !r_p[0]);
    assign ctrl.shift_b = ((r_state == S_FILL) && r_fill_v) || ((r_state == S_EX) && r_p[0]);
    assign ctrl.compute = (r_state == S_EX);

    // Row of lane cells
    for (genvar j = 0; j < BAND_WIDTH; j++) begin : g_cell
        logic [BASE_W-1:0]  ca_dn;
        logic [SCORE_W-1:0] gv_dn;
        logic [BASE_W-1:0]  cb_up;
        logic [SCORE_W-1:0] gh_up;

        if (j == 0) begin : g_lo
            assign ca_dn = new_a;
            assign gv_dn = '0;
        end else begin : g_lo_n
            assign ca_dn = w_ca[j-1];
            assign gv_dn = w_gv[j-1];
        end

        if (j == BAND_WIDTH - 1) begin : g_hi
            assign cb_up = new_b;
            assign gh_up = '0;
        end else begin : g_hi_n
            assign cb_up = w_cb[j+1];
            assign gh_up = w_gh[j+1];
        end

        bafa_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_cfg      (scfg),
            .i_lane     (LANE_W'(j)),
            .i_ca_dn    (ca_dn),
            .i_gv_dn    (gv_dn),
            .i_cb_up    (cb_up),
            .i_gh_up    (gh_up),
            .o_ca       (w_ca[j]),
            .o_cb       (w_cb[j]),
            .o_gh       (w_gh[j]),
            .o_gv       (w_gv[j]),
            .o_cur      (w_cur[j]),
            .o_prev_ofs (w_pofs[j])
        );
    end

    // Lowest seed lane holding exactly the offset
    always_comb begin
        enc_lane = LANE_W'(HALF);
        for (int j = BAND_WIDTH - 1; j >= 0; j--) begin
            if (w_pofs[j]) begin
                enc_lane = LANE_W'(j);
            end
        end
    end

    bafa_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (r_ex_done),
        .i_step  (r_ex_p),
        .i_vals  (w_cur),
        .o_cand  (cand)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && i_last) begin
                    n_state = seq_empty ? S_OUT : S_FILL;
                end
            end
            S_FILL: begin
                if (r_cnt == CNT_W'(HALF)) begin
                    n_state = S_SEED;
                end
            end
            S_SEED:  n_state = S_ENC;
            S_ENC:   n_state = S_RD;
            S_RD:    n_state = S_EX;
            S_EX:    n_state = (r_p == r_total) ? S_DRAIN : S_RD;
            S_DRAIN: begin
                if (!r_ex_done && !cand.valid) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (acc_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // End positions from the best step and lane
    assign q        = STEP_W'(signed'({1'b0, r_best_lane}) - (LANE_W+1)'(HALF));
    assign step_inc = {1'b0, r_best_step} + (STEP_W+1)'(1);
    assign a_pos    = {1'b0, r_best_step[STEP_W-1:1]} - q;
    assign b_pos    = step_inc[STEP_W:1] + q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_fill_v    <= 1'b0;
            r_ex_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill_v  <= (r_state == S_FILL) && (r_cnt < CNT_W'(HALF));
            r_ex_done <= (r_state == S_EX);
            // Append, and empty both sequences once the result is taken
            if (acc_out) begin
                r_len_a <= '0;
                r_len_b <= '0;
            end else if (acc_in) begin
                r_len_a <= n_len_a;
                r_len_b <= n_len_b;
            end
            // Result register
            if (acc_in && i_last && seq_empty) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_DRAIN) && (n_state == S_OUT)) begin
                r_out_valid <= 1'b1;
            end else if (acc_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_in_a <= rd_idx < STEP_W'(r_len_a);
        r_in_b <= rd_idx < STEP_W'(r_len_b);
        if (acc_in && i_last) begin
            r_total <= STEP_W'(n_len_a) + STEP_W'(n_len_b);
            r_cnt   <= '0;
        end else if (r_state == S_FILL) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == S_EX) begin
            r_ex_p <= r_p;
        end
        // Step counter starts at the second anti-diagonal
        if (r_state == S_ENC) begin
            r_p <= STEP_W'(2);
        end else if (r_state == S_EX) begin
            r_p <= r_p + STEP_W'(1);
        end
        // Running maximum, first occurrence kept
        if (r_state == S_ENC) begin
            r_best      <= SCORE_W'(OFS);
            r_best_step <= '0;
            r_best_lane <= enc_lane;
        end else if (cand.valid && (cand.value > r_best)) begin
            r_best      <= cand.value;
            r_best_step <= cand.step;
            r_best_lane <= cand.lane;
        end
        if (acc_in && i_last && seq_empty) begin
            r_score <= '0;
            r_a_end <= '0;
            r_b_end <= '0;
        end else if ((r_state == S_DRAIN) && (n_state == S_OUT)) begin
            r_score <= 15'(r_best - SCORE_W'(OFS));
            r_a_end <= a_pos[12:0];
            r_b_end <= b_pos[12:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_a_end     = r_a_end;
    assign o_b_end     = r_b_end;

endmodule

`default_nettype wire

// ===== rtl/core/bafa_seqmem.sv =====
// ----------------------------------------------------------------------------
// bafa_seqmem
// Base store for one sequence: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bafa_seqmem
    import bafa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [BASE_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [BASE_W-1:0] o_rdata
);

    logic [BASE_W-1:0] r_mem [MAX_LEN];

    // Write on load
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bafa_cell.sv =====
// ----------------------------------------------------------------------------
// bafa_cell
// One band lane: holds the lane's bases, scores and gap scores and computes
// one affine-gap cell per anti-diagonal step.
// ----------------------------------------------------------------------------
`default_nettype none

module bafa_cell
    import bafa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire t_score_cfg         i_cfg,
    input  wire logic [LANE_W-1:0]  i_lane,
    input  wire logic [BASE_W-1:0]  i_ca_dn,   // a base from the lane below
    input  wire logic [SCORE_W-1:0] i_gv_dn,   // vertical gap from the lane below
    input  wire logic [BASE_W-1:0]  i_cb_up,   // b base from the lane above
    input  wire logic [SCORE_W-1:0] i_gh_up,   // horizontal gap from the lane above
    output logic      [BASE_W-1:0]  o_ca,
    output logic      [BASE_W-1:0]  o_cb,
    output logic      [SCORE_W-1:0] o_gh,
    output logic      [SCORE_W-1:0] o_gv,
    output logic      [SCORE_W-1:0] o_cur,
    output logic                    o_prev_ofs
);

    logic [BASE_W-1:0]  r_ca;
    logic [BASE_W-1:0]  r_cb;
    logic [SCORE_W-1:0] r_prev;
    logic [SCORE_W-1:0] r_cur;
    logic [SCORE_W-1:0] r_gh;
    logic [SCORE_W-1:0] r_gv;

    logic [BASE_W-1:0]  ca_n;
    logic [BASE_W-1:0]  cb_n;
    logic [SCORE_W-1:0] pe;
    logic [SCORE_W-1:0] pf;
    logic               is_match;
    logic signed [5:0]  sc;
    logic signed [17:0] sum;
    logic [SCORE_W-1:0] v0;
    logic [SCORE_W-1:0] e0;
    logic [SCORE_W-1:0] f0;
    logic [SCORE_W-1:0] vm;
    logic [SCORE_W-1:0] v;
    logic [SCORE_W-1:0] vo;
    logic [SCORE_W-1:0] e;
    logic [SCORE_W-1:0] f;
    logic [SCORE_W-1:0] gxm;
    logic [SCORE_W-1:0] gom;
    t_cell_seed         seed;

    assign seed = seed_lane(int'(i_lane), i_cfg);
    assign gxm  = SCORE_W'(i_cfg.gxm);
    assign gom  = SCORE_W'(i_cfg.gom);

    // Bases after this step's band move; an odd step moves down
    assign ca_n = i_ctrl.shift_a ? i_ca_dn : r_ca;
    assign cb_n = i_ctrl.shift_b ? i_cb_up : r_cb;
    assign pe   = i_ctrl.shift_b ? i_gh_up : r_gh;
    assign pf   = i_ctrl.shift_b ? r_gv : i_gv_dn;

    // Substitution with saturation to the score range
    assign is_match = (ca_n < BASE_N) && (cb_n < BASE_N) && (ca_n == cb_n);
    assign sc  = is_match ? $signed({2'b00, i_cfg.ma}) : $signed({i_cfg.mi[4], i_cfg.mi});
    assign sum = $signed({2'b00, r_prev}) + 18'(sc);
    assign v0  = sum[17] ? '0 : (sum[16] ? '1 : sum[15:0]);

    // Gap extension and opening, saturating at zero
    assign e0 = (pe > gxm) ? pe - gxm : '0;
    assign f0 = (pf > gxm) ? pf - gxm : '0;
    assign vm = (e0 > f0) ? e0 : f0;
    assign v  = (v0 > vm) ? v0 : vm;
    assign vo = (v > gom) ? v - gom : '0;
    assign e  = (e0 > vo) ? e0 : vo;
    assign f  = (f0 > vo) ? f0 : vo;

    // Clear, hold, seed, shift or advance the lane
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_ca <= '0;
            r_cb <= '0;
        end else begin
            if (i_ctrl.shift_a) begin
                r_ca <= ca_n;
            end
            if (i_ctrl.shift_b) begin
                r_cb <= cb_n;
            end
        end
        if (i_ctrl.seed) begin
            r_prev <= seed.prev;
            r_cur  <= seed.cur;
            r_gh   <= seed.gh;
            r_gv   <= seed.gv;
        end else if (i_ctrl.compute) begin
            r_prev <= r_cur;
            r_cur  <= v;
            r_gh   <= e;
            r_gv   <= f;
        end
    end

    assign o_ca       = r_ca;
    assign o_cb       = r_cb;
    assign o_gh       = r_gh;
    assign o_gv       = r_gv;
    assign o_cur      = r_cur;
    assign o_prev_ofs = (r_prev == SCORE_W'(OFS));

endmodule

`default_nettype wire

// ===== rtl/core/bafa_reduce.sv =====
// ----------------------------------------------------------------------------
// bafa_reduce
// Two-stage maximum over the band: groups of four lanes, then the groups.
// Ties go to the lowest lane.
// ----------------------------------------------------------------------------
`default_nettype none

module bafa_reduce
    import bafa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire t_band_scores      i_vals,
    output t_cand                  o_cand
);

    logic [SCORE_W-1:0] grp_v [NGRP];
    logic [LANE_W-1:0]  grp_l [NGRP];
    logic [SCORE_W-1:0] r_grp_v [NGRP];
    logic [LANE_W-1:0]  r_grp_l [NGRP];
    logic               r_valid;
    logic [STEP_W-1:0]  r_step;
    logic [SCORE_W-1:0] fin_v;
    logic [LANE_W-1:0]  fin_l;

    // First maximum inside each group of four
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_v[g] = '0;
            grp_l[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if (i_vals[4 * g + k] > grp_v[g]) begin
                    grp_v[g] = i_vals[4 * g + k];
                    grp_l[g] = LANE_W'(4 * g + k);
                end
            end
        end
    end

    // Hold group results and their step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        if (i_take) begin
            r_grp_v <= grp_v;
            r_grp_l <= grp_l;
            r_step  <= i_step;
        end
    end

    // First maximum over the groups
    always_comb begin
        fin_v = '0;
        fin_l = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_grp_v[g] > fin_v) begin
                fin_v = r_grp_v[g];
                fin_l = r_grp_l[g];
            end
        end
    end

    assign o_cand.valid = r_valid;
    assign o_cand.value = fin_v;
    assign o_cand.lane  = fin_l;
    assign o_cand.step  = r_step;

endmodule

`default_nettype wire

// ===== rtl/core/bafa_checker.sv =====
// ----------------------------------------------------------------------------
// bafa_checker
// Port-level checks on the aligner's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bafa_checker
    import bafa_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               i_last,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [14:0]        o_score,
    input wire logic [12:0]        o_a_end,
    input wire logic [12:0]        o_b_end
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_score) && $stable(o_a_end)
                                       && $stable(o_b_end))
        else $error("result changed while stalled");

    // No load is taken while a result is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // A last transaction closes the input until its result is taken
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last |=> o_in_stall)
        else $error("input open after last transaction");

    // The result needs a last transaction first
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall && $past(o_in_stall || i_last))
        else $error("result without last transaction");

endmodule

bind banded_affine_alignment_top bafa_checker u_bafa_checker (.*);

`default_nettype wire
